// ===== rtl/ghcs_pkg.sv =====
// Shared types, widths and constants of the hopping channel selector.
// Holds the random-number table and the reciprocal constants of the frame splitter.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ghcs_pkg;

  // Field widths
  localparam int unsigned FN_W     = 22;
  localparam int unsigned IDX_W    = 6;
  localparam int unsigned CHAN_W   = 10;
  localparam int unsigned HSN_W    = 6;
  localparam int unsigned LEN_W    = 7;
  localparam int unsigned RN_W     = 7;
  localparam int unsigned DIVD_W   = FN_W + 1;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 7;

  localparam int unsigned DEPTH_DEFAULT = 64;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_HOP_SEQ   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ALLOC_OFS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ALLOC_LEN = 2'd2;

  // Item operation codes
  typedef enum logic {
    OP_WRITE   = 1'b0,
    OP_COMPUTE = 1'b1
  } op_e;

  // Payload that travels with an item down the pipeline
  typedef struct packed {
    op_e               op;
    logic [IDX_W-1:0]  slot;
    logic [CHAN_W-1:0] chan;
  } tag_t;

  // Frame number split: q = (fn * RECIP) >> RECIP_SHIFT is exact or one short
  localparam int unsigned RECIP_SHIFT = 22;
  localparam int unsigned Q1_W  = 12;
  localparam int unsigned Q26_W = 18;
  localparam int unsigned Q51_W = 17;
  localparam logic [Q1_W-1:0]  RECIP_1326 = 12'd3163;
  localparam logic [Q26_W-1:0] RECIP_26   = 18'd161319;
  localparam logic [Q51_W-1:0] RECIP_51   = 17'd82241;
  localparam logic [10:0]      DIV_T1     = 11'd1326;
  localparam logic [4:0]       DIV_T2     = 5'd26;
  localparam logic [5:0]       DIV_T3     = 6'd51;

  // Remainder pipeline shape
  localparam int unsigned REM_STAGES = 4;
  localparam int unsigned REM_STEP   = 6;
  localparam int unsigned REM_W      = REM_STAGES * REM_STEP;

  // Random-number table of the hopping sequence
  localparam logic [RN_W-1:0] RN_TABLE [0:113] = '{
    7'd48,  7'd98,  7'd63,  7'd1,   7'd36,  7'd95,  7'd78,  7'd102, 7'd94,  7'd73,
    7'd0,   7'd64,  7'd25,  7'd81,  7'd76,  7'd59,  7'd124, 7'd23,  7'd104, 7'd100,
    7'd101, 7'd47,  7'd118, 7'd85,  7'd18,  7'd56,  7'd96,  7'd86,  7'd54,  7'd2,
    7'd80,  7'd34,  7'd127, 7'd13,  7'd6,   7'd89,  7'd57,  7'd103, 7'd12,  7'd74,
    7'd55,  7'd111, 7'd75,  7'd38,  7'd109, 7'd71,  7'd112, 7'd29,  7'd11,  7'd88,
    7'd87,  7'd19,  7'd3,   7'd68,  7'd110, 7'd26,  7'd33,  7'd31,  7'd8,   7'd45,
    7'd82,  7'd58,  7'd40,  7'd107, 7'd32,  7'd5,   7'd106, 7'd92,  7'd62,  7'd67,
    7'd77,  7'd108, 7'd122, 7'd37,  7'd60,  7'd66,  7'd121, 7'd42,  7'd51,  7'd126,
    7'd117, 7'd114, 7'd4,   7'd90,  7'd43,  7'd52,  7'd53,  7'd113, 7'd120, 7'd72,
    7'd16,  7'd49,  7'd7,   7'd79,  7'd119, 7'd61,  7'd22,  7'd84,  7'd9,   7'd97,
    7'd91,  7'd15,  7'd21,  7'd24,  7'd46,  7'd39,  7'd93,  7'd105, 7'd65,  7'd70,
    7'd125, 7'd99,  7'd17,  7'd123
  };

endpackage

`default_nettype wire

// ===== rtl/ghcs_hop.sv =====
// Front end of the selector: splits the frame number, walks the hopping
// sequence and produces the dividend that is reduced modulo N downstream.
// Depends on ghcs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ghcs_hop (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        adv_i,
  input  wire logic                        vld_i,
  input  wire ghcs_pkg::tag_t              tag_i,
  input  wire logic [ghcs_pkg::FN_W-1:0]   fn_i,
  input  wire logic [ghcs_pkg::HSN_W-1:0]  hsn_i,
  input  wire logic [ghcs_pkg::IDX_W-1:0]  maio_i,
  input  wire logic [ghcs_pkg::LEN_W-1:0]  len_i,
  output logic                             vld_o,
  output ghcs_pkg::tag_t                   tag_o,
  output logic [ghcs_pkg::DIVD_W-1:0]      divd_o
);
  import ghcs_pkg::*;

  // Fold the hop value into 0..N-1; the value is below 4N here
  function automatic logic [LEN_W-1:0] fold3(input logic [LEN_W:0] x_in,
                                             input logic [LEN_W-1:0] n);
    logic [LEN_W:0] x;
    x = x_in;
    for (int i = 0; i < 3; i++) begin
      if (x >= {1'b0, n}) begin
        x = x - {1'b0, n};
      end
    end
    return x[LEN_W-1:0];
  endfunction

  logic [3:0] vld_q;
  tag_t       tag_a_q, tag_b_q, tag_c_q, tag_d_q;

  // Stage A: reciprocal estimates of the three quotients
  logic [FN_W+Q1_W-1:0]  p1;
  logic [FN_W+Q26_W-1:0] p26;
  logic [FN_W+Q51_W-1:0] p51;
  logic [FN_W-1:0]       fn_a_q;
  logic [Q1_W-1:0]       q1_a_q;
  logic [Q26_W-1:0]      q26_a_q;
  logic [Q51_W-1:0]      q51_a_q;

  assign p1  = fn_i * RECIP_1326;
  assign p26 = fn_i * RECIP_26;
  assign p51 = fn_i * RECIP_51;

  // Stage B: remainders with one correction step
  logic [FN_W:0]   m1, m26, m51;
  logic [FN_W-1:0] r1, r26, r51;
  logic [5:0]      t1_b_d;
  logic [4:0]      t2_b_d;
  logic [5:0]      t3_b_d;
  logic [5:0]      t1_b_q;
  logic [4:0]      t2_b_q;
  logic [5:0]      t3_b_q;
  logic [DIVD_W-1:0] cyc_b_d, cyc_b_q;

  assign m1  = q1_a_q * DIV_T1;
  assign m26 = q26_a_q * DIV_T2;
  assign m51 = q51_a_q * DIV_T3;
  assign r1  = fn_a_q - m1[FN_W-1:0];
  assign r26 = fn_a_q - m26[FN_W-1:0];
  assign r51 = fn_a_q - m51[FN_W-1:0];

  always_comb begin
    t1_b_d = (r1 >= FN_W'(DIV_T1)) ? (q1_a_q[5:0] + 6'd1) : q1_a_q[5:0];
    t2_b_d = (r26 >= FN_W'(DIV_T2)) ? 5'(r26 - FN_W'(DIV_T2)) : r26[4:0];
    t3_b_d = (r51 >= FN_W'(DIV_T3)) ? 6'(r51 - FN_W'(DIV_T3)) : r51[5:0];
    cyc_b_d = {1'b0, fn_a_q} + DIVD_W'(maio_i);
  end

  // Stage C: random-number lookup, M = T2 + RN[(HSN ^ T1) + T3]
  logic [RN_W-1:0]   rn_idx;
  logic [RN_W-1:0]   rn_val;
  logic [RN_W:0]     m_c_d, m_c_q;
  logic [5:0]        t3_c_q;
  logic [DIVD_W-1:0] cyc_c_q;

  assign rn_idx = RN_W'(hsn_i ^ t1_b_q) + RN_W'(t3_b_q);
  assign rn_val = RN_TABLE[rn_idx];
  assign m_c_d  = (RN_W+1)'(rn_val) + (RN_W+1)'(t2_b_q);

  // Stage D: reduce by the power of two above N, fold, add offset; HSN 0 takes FN + MAIO instead
  logic [LEN_W-1:0]  mask, mr, tr, s_hop;
  logic [LEN_W-1:0]  v_hop;
  logic [DIVD_W-1:0] divd_d, divd_q;

  always_comb begin
    mask  = len_i | (len_i >> 1) | (len_i >> 2) | (len_i >> 3)
          | (len_i >> 4) | (len_i >> 5) | (len_i >> 6);
    mr    = m_c_q[LEN_W-1:0] & mask;
    tr    = LEN_W'(t3_c_q) & mask;
    s_hop = (mr < len_i) ? mr : fold3((LEN_W+1)'(mr) + (LEN_W+1)'(tr), len_i);
    v_hop = LEN_W'(maio_i) + s_hop;
    divd_d = (hsn_i == '0) ? cyc_c_q : DIVD_W'(v_hop);
  end

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv_i) begin
      vld_q <= {vld_q[2:0], vld_i};
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      tag_a_q <= tag_i;
      fn_a_q  <= fn_i;
      q1_a_q  <= p1[RECIP_SHIFT +: Q1_W];
      q26_a_q <= p26[RECIP_SHIFT +: Q26_W];
      q51_a_q <= p51[RECIP_SHIFT +: Q51_W];

      tag_b_q <= tag_a_q;
      t1_b_q  <= t1_b_d;
      t2_b_q  <= t2_b_d;
      t3_b_q  <= t3_b_d;
      cyc_b_q <= cyc_b_d;

      tag_c_q <= tag_b_q;
      m_c_q   <= m_c_d;
      t3_c_q  <= t3_b_q;
      cyc_c_q <= cyc_b_q;

      tag_d_q <= tag_c_q;
      divd_q  <= divd_d;
    end
  end

  assign vld_o  = vld_q[3];
  assign tag_o  = tag_d_q;
  assign divd_o = divd_q;

endmodule

`default_nettype wire

// ===== rtl/ghcs_rem.sv =====
// Pipelined restoring remainder: dividend modulo N, six bits per stage.
// Carries the item payload alongside. Depends on ghcs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ghcs_rem (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        adv_i,
  input  wire logic                        vld_i,
  input  wire ghcs_pkg::tag_t              tag_i,
  input  wire logic [ghcs_pkg::DIVD_W-1:0] divd_i,
  input  wire logic [ghcs_pkg::LEN_W-1:0]  len_i,
  output logic                             vld_o,
  output ghcs_pkg::tag_t                   tag_o,
  output logic [ghcs_pkg::IDX_W-1:0]       idx_o
);
  import ghcs_pkg::*;

  // Shift in REM_STEP dividend bits, compare-subtract after each
  function automatic logic [LEN_W-1:0] rem_steps(input logic [LEN_W-1:0]    r_in,
                                                 input logic [REM_STEP-1:0] bits,
                                                 input logic [LEN_W-1:0]    n);
    logic [LEN_W:0] r;
    r = {1'b0, r_in};
    for (int i = REM_STEP - 1; i >= 0; i--) begin
      r = {r[LEN_W-1:0], bits[i]};
      if (r >= {1'b0, n}) begin
        r = r - {1'b0, n};
      end
    end
    return r[LEN_W-1:0];
  endfunction

  logic [REM_STAGES-1:0] vld_q;
  tag_t                  tag_q [REM_STAGES];
  logic [REM_W-1:0]      dvd_q [REM_STAGES];
  logic [LEN_W-1:0]      rem_q [REM_STAGES];
  logic [REM_W-1:0]      dvd_in;

  assign dvd_in = REM_W'(divd_i);

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv_i) begin
      vld_q <= {vld_q[REM_STAGES-2:0], vld_i};
    end
  end

  // Remainder stages, most significant bits first
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      tag_q[0] <= tag_i;
      dvd_q[0] <= dvd_in;
      rem_q[0] <= rem_steps('0, dvd_in[REM_W-1 -: REM_STEP], len_i);
      for (int s = 1; s < REM_STAGES; s++) begin
        tag_q[s] <= tag_q[s-1];
        dvd_q[s] <= dvd_q[s-1];
        rem_q[s] <= rem_steps(rem_q[s-1], dvd_q[s-1][REM_W-1-s*REM_STEP -: REM_STEP], len_i);
      end
    end
  end

  assign vld_o = vld_q[REM_STAGES-1];
  assign tag_o = tag_q[REM_STAGES-1];
  assign idx_o = rem_q[REM_STAGES-1][IDX_W-1:0];

endmodule

`default_nettype wire

// ===== rtl/gsm_hopping_channel_select.sv =====
// Top level of the frequency hopping channel selector: configuration
// registers, allocation table memory and output register.
// Depends on ghcs_pkg, ghcs_hop and ghcs_rem.
//
//   channel   signals                                      direction
//   --------  -------------------------------------------  ---------
//   in        in_valid_i / in_ready_o, op_i, frame_number_i,  input
//             entry_index_i, entry_channel_i
//   out       out_valid_o / out_ready_i, channel_o,           output
//             alloc_index_o
//   cfg       cfg_we_i, cfg_idx_i, cfg_wdata_i                input
//
// One item per cycle in steady state, unless the output stalls. A compute
// item passes 4 stages of frame arithmetic, 4 stages of the modulo-N
// remainder and the table read, whose registered data is the output item.
// Table writes travel the same stages, so reads and writes stay in order.
// Reset clears the valid bits and loads the registers with 0, 0 and 1; the
// table holds no reset value. A stalled output freezes the whole pipeline.
`timescale 1ns / 1ps
`default_nettype none

module gsm_hopping_channel_select #(
  parameter int unsigned ALLOC_DEPTH = ghcs_pkg::DEPTH_DEFAULT
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // Configuration
  input  wire logic                           cfg_we_i,
  input  wire logic [ghcs_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [ghcs_pkg::CFG_DAT_W-1:0] cfg_wdata_i,
  // Input items
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic                           op_i,
  input  wire logic [ghcs_pkg::FN_W-1:0]      frame_number_i,
  input  wire logic [ghcs_pkg::IDX_W-1:0]     entry_index_i,
  input  wire logic [ghcs_pkg::CHAN_W-1:0]    entry_channel_i,
  // Output items
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic [ghcs_pkg::CHAN_W-1:0]         channel_o,
  output logic [ghcs_pkg::IDX_W-1:0]          alloc_index_o
);
  import ghcs_pkg::*;

  localparam int unsigned AW = (ALLOC_DEPTH > 1) ? $clog2(ALLOC_DEPTH) : 1;

  // Configuration registers
  logic [HSN_W-1:0] hsn_q;
  logic [IDX_W-1:0] maio_q;
  logic [LEN_W-1:0] len_q;
  logic [LEN_W-1:0] n_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hsn_q  <= '0;
      maio_q <= '0;
      len_q  <= LEN_W'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_HOP_SEQ:   hsn_q  <= cfg_wdata_i[HSN_W-1:0];
        CFG_ALLOC_OFS: maio_q <= cfg_wdata_i[IDX_W-1:0];
        CFG_ALLOC_LEN: len_q  <= cfg_wdata_i[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective N: zero reads as one, saturate at the table depth
  always_comb begin
    if (len_q == '0) begin
      n_eff = LEN_W'(1);
    end else if (len_q > LEN_W'(ALLOC_DEPTH)) begin
      n_eff = LEN_W'(ALLOC_DEPTH);
    end else begin
      n_eff = len_q;
    end
  end

  // Pipeline advances whenever the output register is free or drained
  logic adv;
  logic out_valid_q;

  assign adv        = !out_valid_q || out_ready_i;
  assign in_ready_o = adv;

  tag_t in_tag;
  assign in_tag.op   = op_e'(op_i);
  assign in_tag.slot = entry_index_i;
  assign in_tag.chan = entry_channel_i;

  // Frame arithmetic
  logic              hop_vld;
  tag_t              hop_tag;
  logic [DIVD_W-1:0] hop_divd;

  ghcs_hop u_hop (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .vld_i  (in_valid_i),
    .tag_i  (in_tag),
    .fn_i   (frame_number_i),
    .hsn_i  (hsn_q),
    .maio_i (maio_q),
    .len_i  (n_eff),
    .vld_o  (hop_vld),
    .tag_o  (hop_tag),
    .divd_o (hop_divd)
  );

  // Modulo-N reduction
  logic             rem_vld;
  tag_t             rem_tag;
  logic [IDX_W-1:0] rem_idx;

  ghcs_rem u_rem (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .vld_i  (hop_vld),
    .tag_i  (hop_tag),
    .divd_i (hop_divd),
    .len_i  (n_eff),
    .vld_o  (rem_vld),
    .tag_o  (rem_tag),
    .idx_o  (rem_idx)
  );

  // Allocation table: one write or one read per item, read data registered
  logic [CHAN_W-1:0] mem [ALLOC_DEPTH];
  logic [CHAN_W-1:0] chan_q;
  logic [IDX_W-1:0]  idx_q;
  logic              do_write, do_read;

  assign do_write = rem_vld && (rem_tag.op == OP_WRITE)
                 && ({1'b0, rem_tag.slot} < LEN_W'(ALLOC_DEPTH));
  assign do_read  = rem_vld && (rem_tag.op == OP_COMPUTE);

  always_ff @(posedge clk_i) begin
    if (adv && do_write) begin
      mem[rem_tag.slot[AW-1:0]] <= rem_tag.chan;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && do_read) begin
      chan_q <= mem[rem_idx[AW-1:0]];
      idx_q  <= rem_idx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= do_read;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign channel_o     = chan_q;
  assign alloc_index_o = idx_q;

endmodule

`default_nettype wire
